FILE: src/tsc_pkg.sv
package tsc_pkg;

  // Event types and codes
  localparam logic [15:0] EvtSyn        = 16'h0000;
  localparam logic [15:0] EvtKey        = 16'h0001;
  localparam logic [15:0] EvtAbs        = 16'h0003;
  localparam logic [15:0] CodeAxX       = 16'h0000;
  localparam logic [15:0] CodeAxY       = 16'h0001;
  localparam logic [15:0] CodeMtX       = 16'h0035;
  localparam logic [15:0] CodeMtY       = 16'h0036;
  localparam logic [15:0] CodeBtnTouch  = 16'h014a;
  localparam logic [15:0] CodeBtnLeft   = 16'h0110;
  localparam logic [15:0] CodeSynReport = 16'h0000;

  // Configuration register indexes
  localparam logic [2:0] RegXMin    = 3'd0;
  localparam logic [2:0] RegXSpan   = 3'd1;
  localparam logic [2:0] RegYMin    = 3'd2;
  localparam logic [2:0] RegYSpan   = 3'd3;
  localparam logic [2:0] RegScreenW = 3'd4;
  localparam logic [2:0] RegScreenH = 3'd5;

  typedef struct packed {
    logic [15:0]        event_type;
    logic [15:0]        event_code;
    logic signed [31:0] event_value;
  } event_t;

  typedef struct packed {
    logic signed [31:0] screen_x;
    logic signed [31:0] screen_y;
    logic               touch_down;
  } coord_t;

  // One axis job for the shared scaling unit
  typedef struct packed {
    logic [31:0] raw;
    logic [31:0] amin;
    logic [30:0] span;
    logic [15:0] size;
  } axis_req_t;

endpackage

FILE: src/tsc_scale_unit.sv
module tsc_scale_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  tsc_pkg::axis_req_t   req,
  output logic                 done,
  output logic [31:0]          result
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_MUL,
    S_DIV
  } state_t;

  state_t             state;
  tsc_pkg::axis_req_t req_q;
  logic [32:0]        diff;
  logic [30:0]        mul_a;
  logic [30:0]        rem;
  logic [15:0]        lo;
  logic [3:0]         count;

  logic [46:0] prod;
  logic [31:0] trial;
  logic        qbit;
  logic [30:0] rem_next;
  logic [15:0] lo_next;

  // Quotient is known to fit 16 bits: only 16 restoring steps are needed.
  always_comb begin
    prod     = {16'b0, mul_a} * {31'b0, req_q.size};
    trial    = {rem, lo[15]};
    qbit     = (trial >= {1'b0, req_q.span});
    rem_next = qbit ? 31'(trial - {1'b0, req_q.span}) : trial[30:0];
    lo_next  = {lo[14:0], qbit};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (start) begin
            req_q <= req;
            diff  <= {req.raw[31], req.raw} - {req.amin[31], req.amin};
            state <= S_CHECK;
          end
        end
        S_CHECK: begin
          if (req_q.span == 31'd0) begin
            result <= req_q.raw;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (req_q.size == 16'd0) begin
            // zero screen: even a zero quotient reaches size, all ones
            result <= {16'b0, req_q.size} - 32'd1;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (diff[32]) begin
            result <= 32'd0;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else if (diff >= {2'b00, req_q.span}) begin
            // quotient reaches size: clamp
            result <= {16'b0, req_q.size} - 32'd1;
            done   <= 1'b1;
            state  <= S_IDLE;
          end else begin
            mul_a <= diff[30:0];
            state <= S_MUL;
          end
        end
        S_MUL: begin
          rem   <= prod[46:16];
          lo    <= prod[15:0];
          count <= 4'd0;
          state <= S_DIV;
        end
        S_DIV: begin
          rem   <= rem_next;
          lo    <= lo_next;
          count <= count + 4'd1;
          if (count == 4'd15) begin
            result <= {16'b0, lo_next};
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: src/touch_event_to_screen_coords_core.sv
// Channel   Dir  Handshake              Payload
// in        in   in_valid / in_ready    tsc_pkg::event_t  (type, code, value)
// out       out  out_valid / out_ready  tsc_pkg::coord_t  (x, y, touch_down)
// cfg       in   cfg_wr_en              cfg_index[2:0], cfg_data[31:0]
//
// Axis and key events are absorbed in IDLE; the block stays ready.
// A sync report holds the input while the scaling unit, per axis, registers the
// difference, runs the range check, passes through the 31x16 multiplier and takes
// 16 restoring divide steps; x and y go one after the other through the same
// scaling unit, then the output register is loaded. An axis that passes through
// or clamps is done after its check.
// A finished result sits in the output register; the next transaction is taken
// while it waits, and a later report holds in FINISH until the slot is free.
// Reset (rst, synchronous) restores register defaults and raw position 400/240.
module touch_event_to_screen_coords_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  tsc_pkg::event_t  in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output tsc_pkg::coord_t  out_data,
  input  logic             cfg_wr_en,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN_X,
    ST_RUN_Y,
    ST_FINISH
  } state_t;

  state_t state;

  // configuration registers
  logic [31:0] x_axis_min;
  logic [30:0] x_axis_span;
  logic [31:0] y_axis_min;
  logic [30:0] y_axis_span;
  logic [15:0] screen_width;
  logic [15:0] screen_height;

  // event state
  logic [31:0] latest_raw_x;
  logic [31:0] latest_raw_y;
  logic        held_flag;
  logic [31:0] scaled_x;
  logic [31:0] scaled_y;

  logic               in_xact;
  logic               is_report;
  logic               out_load;
  logic               unit_start;
  tsc_pkg::axis_req_t unit_req;
  logic               unit_done;
  logic [31:0]        unit_result;

  assign in_ready  = (state == ST_IDLE);
  assign in_xact   = in_valid && in_ready;
  assign is_report = (in_data.event_type == tsc_pkg::EvtSyn) &&
                     (in_data.event_code == tsc_pkg::CodeSynReport);

  // result moves into the output register once the slot is free or draining
  assign out_load  = (state == ST_FINISH) && (!out_valid || out_ready);

  // x job starts on the report transaction, y job right when x finishes
  assign unit_start = (in_xact && is_report) || ((state == ST_RUN_X) && unit_done);

  always_comb begin
    if (state == ST_RUN_X) begin
      unit_req.raw  = latest_raw_y;
      unit_req.amin = y_axis_min;
      unit_req.span = y_axis_span;
      unit_req.size = screen_height;
    end else begin
      unit_req.raw  = latest_raw_x;
      unit_req.amin = x_axis_min;
      unit_req.span = x_axis_span;
      unit_req.size = screen_width;
    end
  end

  tsc_scale_unit u_scale (
    .clk    (clk),
    .rst    (rst),
    .start  (unit_start),
    .req    (unit_req),
    .done   (unit_done),
    .result (unit_result)
  );

  // configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      x_axis_min    <= 32'd0;
      x_axis_span   <= 31'd799;
      y_axis_min    <= 32'd0;
      y_axis_span   <= 31'd479;
      screen_width  <= 16'd800;
      screen_height <= 16'd480;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        tsc_pkg::RegXMin:    x_axis_min    <= cfg_data;
        tsc_pkg::RegXSpan:   x_axis_span   <= cfg_data[30:0];
        tsc_pkg::RegYMin:    y_axis_min    <= cfg_data;
        tsc_pkg::RegYSpan:   y_axis_span   <= cfg_data[30:0];
        tsc_pkg::RegScreenW: screen_width  <= cfg_data[15:0];
        tsc_pkg::RegScreenH: screen_height <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      out_valid    <= 1'b0;
      latest_raw_x <= 32'd400;
      latest_raw_y <= 32'd240;
      held_flag    <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_xact) begin
            if (in_data.event_type == tsc_pkg::EvtAbs) begin
              if ((in_data.event_code == tsc_pkg::CodeAxX) ||
                  (in_data.event_code == tsc_pkg::CodeMtX)) begin
                latest_raw_x <= in_data.event_value;
              end else if ((in_data.event_code == tsc_pkg::CodeAxY) ||
                           (in_data.event_code == tsc_pkg::CodeMtY)) begin
                latest_raw_y <= in_data.event_value;
              end
            end else if (in_data.event_type == tsc_pkg::EvtKey) begin
              if ((in_data.event_code == tsc_pkg::CodeBtnTouch) ||
                  (in_data.event_code == tsc_pkg::CodeBtnLeft)) begin
                held_flag <= (in_data.event_value != 32'sd0);
              end
            end else if (is_report) begin
              state <= ST_RUN_X;
            end
          end
        end
        ST_RUN_X: begin
          if (unit_done) begin
            scaled_x <= unit_result;
            state    <= ST_RUN_Y;
          end
        end
        ST_RUN_Y: begin
          if (unit_done) begin
            scaled_y <= unit_result;
            state    <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          // wait for the output slot to drain
          if (out_load) begin
            out_data.screen_x   <= scaled_x;
            out_data.screen_y   <= scaled_y;
            out_data.touch_down <= held_flag;
            state               <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
